[design/gpd_pkg.sv]
package gpd_pkg;

  localparam int unsigned PacketBytes  = 16;
  localparam int unsigned PosW         = 5;
  localparam int unsigned PayloadFirst = 6;
  localparam int unsigned PayloadLen   = 9;
  localparam int unsigned IdxW         = $clog2(PayloadLen);
  localparam int unsigned SyncPosFirst  = 3;
  localparam int unsigned SyncPosSecond = 4;

  localparam logic [15:0] TimeoutReset    = 16'd200;
  localparam logic [7:0]  SyncFirstReset  = 8'd254;
  localparam logic [7:0]  SyncSecondReset = 8'd253;
  localparam logic [15:0] AgeMax          = 16'hFFFF;
  localparam logic [7:0]  AxisBias        = 8'h80;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CFG_TIMEOUT     = 2'd0,
    CFG_SYNC_FIRST  = 2'd1,
    CFG_SYNC_SECOND = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                           valid;
    logic [PayloadLen-1:0][7:0]     payload;
  } commit_t;

  typedef struct packed {
    logic               connected;
    logic [63:0]        hold_counts_low;
    logic [63:0]        hold_counts_high;
    logic [7:0]         right_trigger;
    logic [7:0]         left_trigger;
    logic signed [7:0]  pad_x;
    logic signed [7:0]  pad_y;
    logic signed [7:0]  right_stick_x;
    logic signed [7:0]  right_stick_y;
    logic signed [7:0]  left_stick_x;
    logic signed [7:0]  left_stick_y;
  } result_t;

endpackage

[design/gpd_if.sv]
interface gpd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       packet_start;

  modport source (output valid, output kind, output data_byte, output packet_start,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input packet_start,
                output ready);
endinterface

interface gpd_out_if;
  logic              valid;
  logic              ready;
  logic              connected;
  logic [63:0]       hold_counts_low;
  logic [63:0]       hold_counts_high;
  logic [7:0]        right_trigger;
  logic [7:0]        left_trigger;
  logic signed [7:0] pad_x;
  logic signed [7:0] pad_y;
  logic signed [7:0] right_stick_x;
  logic signed [7:0] right_stick_y;
  logic signed [7:0] left_stick_x;
  logic signed [7:0] left_stick_y;

  modport source (output valid, output connected, output hold_counts_low,
                  output hold_counts_high, output right_trigger, output left_trigger,
                  output pad_x, output pad_y, output right_stick_x, output right_stick_y,
                  output left_stick_x, output left_stick_y, input ready);
  modport sink (input valid, input connected, input hold_counts_low,
                input hold_counts_high, input right_trigger, input left_trigger,
                input pad_x, input pad_y, input right_stick_x, input right_stick_y,
                input left_stick_x, input left_stick_y, output ready);
endinterface

[design/gpd_frame.sv]
module gpd_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        data_byte_i,
  input  logic              packet_start_i,
  input  logic [7:0]        sync_first_i,
  input  logic [7:0]        sync_second_i,
  output gpd_pkg::commit_t  commit_o
);
  import gpd_pkg::*;

  localparam logic [PosW-1:0] LastPos = PosW'(PacketBytes - 1);

  logic [PosW-1:0]            pos_q, pos_d, pos;
  logic                       match_q, match_d, match;
  logic [PayloadLen-1:0][7:0] shadow_q;
  logic [PayloadLen-1:0][7:0] committed_q;
  logic [IdxW-1:0]            shadow_idx;
  logic                       in_payload;
  logic                       fire_commit;

  always_comb begin
    pos   = packet_start_i ? '0 : pos_q;
    match = packet_start_i ? 1'b0 : match_q;
    if (pos == PosW'(SyncPosFirst)) begin
      match = (data_byte_i == sync_first_i);
    end else if (pos == PosW'(SyncPosSecond)) begin
      match = match && (data_byte_i == sync_second_i);
    end
    in_payload = (pos >= PosW'(PayloadFirst)) && (pos < PosW'(PayloadFirst + PayloadLen));
    shadow_idx = IdxW'(pos - PosW'(PayloadFirst));
    fire_commit = 1'b0;
    if (pos == LastPos) begin
      fire_commit = match;
      match_d     = 1'b0;
      pos_d       = pos;
    end else begin
      match_d = match;
      pos_d   = pos + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      match_q <= 1'b0;
    end else if (take_i) begin
      pos_q   <= pos_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && in_payload) begin
      shadow_q[shadow_idx] <= data_byte_i;
    end
    if (take_i && fire_commit) begin
      committed_q <= shadow_q;
    end
  end

  assign commit_o.valid   = take_i && fire_commit;
  assign commit_o.payload = committed_q;

endmodule

[design/gpd_report.sv]
module gpd_report (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  gpd_pkg::commit_t  commit_i,
  input  logic [15:0]       timeout_i,
  output gpd_pkg::result_t  result_o
);
  import gpd_pkg::*;

  logic [15:0]           age_q, age_d;
  logic [7:0][15:0]      hold_q, hold_d;
  logic                  conn;
  logic [7:0]            buttons;

  always_comb begin
    age_d = age_q;
    if (commit_i.valid) begin
      age_d = '0;
    end else if (tick_i && age_q != AgeMax) begin
      age_d = age_q + 16'd1;
    end
    conn    = (age_d < timeout_i);
    buttons = commit_i.payload[0];
    for (int i = 0; i < 8; i++) begin
      if (conn && buttons[i]) begin
        hold_d[i] = (hold_q[i] != AgeMax) ? hold_q[i] + 16'd1 : hold_q[i];
      end else begin
        hold_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q  <= AgeMax;
      hold_q <= '0;
    end else begin
      age_q <= age_d;
      if (tick_i) begin
        hold_q <= hold_d;
      end
    end
  end

  always_comb begin
    result_o                  = '0;
    result_o.connected        = conn;
    result_o.hold_counts_low  = {hold_d[3], hold_d[2], hold_d[1], hold_d[0]};
    result_o.hold_counts_high = {hold_d[7], hold_d[6], hold_d[5], hold_d[4]};
    if (conn) begin
      result_o.right_trigger = commit_i.payload[1];
      result_o.left_trigger  = commit_i.payload[2];
      result_o.pad_x         = signed'(commit_i.payload[3] ^ AxisBias);
      result_o.pad_y         = signed'(commit_i.payload[4] ^ AxisBias);
      result_o.right_stick_x = signed'(commit_i.payload[5] ^ AxisBias);
      result_o.right_stick_y = signed'(commit_i.payload[6] ^ AxisBias);
      result_o.left_stick_x  = signed'(commit_i.payload[7] ^ AxisBias);
      result_o.left_stick_y  = signed'(commit_i.payload[8] ^ AxisBias);
    end
  end

endmodule

[design/gamepad_packet_hold_decoder_unit.sv]
// A tick word's result is registered: it passes the input register, then the result register.
// Throughput: one word per cycle while the output is not stalled; the single input register
// and the result register set the figure, and a result stalled downstream holds one tick.
// Reset: link counts as lost, hold counters zero, byte position zero,
// timeout 200, sync bytes 254 and 253.
module gamepad_packet_hold_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  gpd_in_if.sink      in_i,
  gpd_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import gpd_pkg::*;

  logic             in_valid_q;
  logic             kind_q;
  logic [7:0]       byte_q;
  logic             start_q;
  logic             stage_go;
  logic             take_byte;
  logic             take_tick;
  logic [15:0]      timeout_q;
  logic [7:0]       sync_first_q;
  logic [7:0]       sync_second_q;
  commit_t          commit;
  result_t          result;
  result_t          result_q;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TimeoutReset;
      sync_first_q  <= SyncFirstReset;
      sync_second_q <= SyncSecondReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT:     timeout_q     <= cfg_data_i;
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i[7:0];
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i[7:0];
        default:         ;
      endcase
    end
  end

  assign stage_go  = in_valid_q && ((kind_q == KIND_BYTE) || !out_valid_q || out_o.ready);
  assign take_byte = stage_go && (kind_q == KIND_BYTE);
  assign take_tick = stage_go && (kind_q == KIND_TICK);
  assign in_i.ready = !in_valid_q || stage_go;

  // hold the accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      kind_q  <= in_i.kind;
      byte_q  <= in_i.data_byte;
      start_q <= in_i.packet_start;
    end
  end

  gpd_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take_byte),
    .data_byte_i    (byte_q),
    .packet_start_i (start_q),
    .sync_first_i   (sync_first_q),
    .sync_second_i  (sync_second_q),
    .commit_o       (commit)
  );

  gpd_report u_report (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (take_tick),
    .commit_i  (commit),
    .timeout_i (timeout_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_tick) begin
      result_q <= result;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.connected        = result_q.connected;
  assign out_o.hold_counts_low  = result_q.hold_counts_low;
  assign out_o.hold_counts_high = result_q.hold_counts_high;
  assign out_o.right_trigger    = result_q.right_trigger;
  assign out_o.left_trigger     = result_q.left_trigger;
  assign out_o.pad_x            = result_q.pad_x;
  assign out_o.pad_y            = result_q.pad_y;
  assign out_o.right_stick_x    = result_q.right_stick_x;
  assign out_o.right_stick_y    = result_q.right_stick_y;
  assign out_o.left_stick_x     = result_q.left_stick_x;
  assign out_o.left_stick_y     = result_q.left_stick_y;

endmodule
